FILE: rtl/core/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ASCII digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam logic [6:0] ASCII_ZERO = 7'd48;
  localparam logic [6:0] ASCII_A    = 7'd65;
  localparam logic [4:0] RADIX_DEC  = 5'd10;
  localparam logic [4:0] RADIX_HEX  = 5'd16;
  localparam logic [3:0] DEC_LIMIT  = 4'd10;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  radix;
  } req_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic [3:0] digit_count;
    logic       last;
    logic       error;
  } rsp_t;

  // Control of the digit shift register.
  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
    logic dec;
    logic bit_in;
  } sr_ctrl_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] d_ext;
    d_ext = {3'b000, d};
    if (d < DEC_LIMIT) begin
      digit_to_ascii = ASCII_ZERO + d_ext;
    end else begin
      digit_to_ascii = ASCII_A + d_ext - {3'b000, DEC_LIMIT};
    end
  endfunction

endpackage

FILE: rtl/core/itoa_digit_sr.sv
// ----------------------------------------------------------------------------
// itoa_digit_sr
// Digit shift register: takes a binary value in one bit per cycle (with the
// add-3 correction in decimal mode) and hands digits out from the top.
// ----------------------------------------------------------------------------
module itoa_digit_sr #(
  parameter int MAX_DIGITS = 10
) (
  input  logic             clk,
  input  itoa_pkg::sr_ctrl_t ctrl,
  output logic [3:0]       top_digit,
  output logic             carry_out
);
  import itoa_pkg::*;

  logic [3:0] digits [MAX_DIGITS];
  logic [3:0] adj    [MAX_DIGITS];

  // Add 3 to any decimal digit of five or more before the doubling shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (ctrl.dec && (digits[i] > 4'd4)) begin
        adj[i] = digits[i] + 4'd3;
      end else begin
        adj[i] = digits[i];
      end
    end
  end

  assign top_digit = digits[MAX_DIGITS-1];
  assign carry_out = adj[MAX_DIGITS-1][3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= 4'd0;
      end
    end else if (ctrl.shift_bit) begin
      digits[0] <= {adj[0][2:0], ctrl.bit_in};
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digits[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end else if (ctrl.shift_digit) begin
      digits[0] <= 4'd0;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digits[i] <= digits[i-1];
      end
    end
  end

endmodule

FILE: rtl/core/integer_to_ascii_digits_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Converts an unsigned value to ASCII decimal or hexadecimal digits, most
// significant first, one character per output request.
// ----------------------------------------------------------------------------
// Sequence: the value is converted bit-serially in S_CONV, leading zeros are
//   dropped in S_TRIM, then S_EMIT sends one character per cycle, most
//   significant first, while the output register is free (not stalled).
// Throughput: a new request is taken only once the previous run is back in
//   idle; a bad radix goes through S_ERR to a single error response.
// Reset: rst (synchronous) returns the sequencer to idle and empties the
//   output register; the digit store and value register need no reset.
module integer_to_ascii_digits_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  itoa_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output itoa_pkg::rsp_t out_data
);
  import itoa_pkg::*;

  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_EMIT,
    S_ERR
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic                   dec;
  logic                   ovf;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       left;

  sr_ctrl_t   sr_ctrl;
  logic [3:0] top_digit;
  logic       carry_out;

  logic        in_accept;
  logic        out_free;
  logic        out_load;
  logic        radix_ok;
  logic        trim_step;
  logic [63:0] value_ext;
  logic [31:0] count_ext;

  // Requests are taken only while the sequencer is idle; the output register
  // may still hold the last character of the previous run.
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = ((state == S_EMIT) || (state == S_ERR)) && out_free;
  assign radix_ok  = (in_data.radix == RADIX_DEC) || (in_data.radix == RADIX_HEX);
  assign value_ext = {32'd0, in_data.value};
  assign count_ext = 32'(count);

  // Drop a leading zero only when no digit was lost off the top and more
  // than one digit remains.
  assign trim_step = !ovf && (count > CNT_W'(1)) && (top_digit == 4'd0);

  always_comb begin
    sr_ctrl             = '0;
    sr_ctrl.dec         = dec;
    sr_ctrl.bit_in      = shreg[VALUE_WIDTH-1];
    sr_ctrl.clear       = (state == S_IDLE) && in_accept && radix_ok;
    sr_ctrl.shift_bit   = (state == S_CONV);
    sr_ctrl.shift_digit = ((state == S_TRIM) && trim_step) ||
                          ((state == S_EMIT) && out_free);
  end

  itoa_digit_sr #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digit_sr (
    .clk      (clk),
    .ctrl     (sr_ctrl),
    .top_digit(top_digit),
    .carry_out(carry_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load a new character when one is ready, else release the output
      // register once taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (radix_ok) begin
              shreg   <= value_ext[VALUE_WIDTH-1:0];
              bit_cnt <= BIT_CNT_W'(VALUE_WIDTH - 1);
              dec     <= (in_data.radix == RADIX_DEC);
              ovf     <= 1'b0;
              state   <= S_CONV;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_CONV: begin
          // Advance one value bit into the digit register, MSB first.
          shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
          ovf   <= ovf | carry_out;
          if (bit_cnt == '0) begin
            count <= CNT_W'(MAX_DIGITS);
            state <= S_TRIM;
          end else begin
            bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          end
        end
        S_TRIM: begin
          if (trim_step) begin
            count <= count - CNT_W'(1);
          end else begin
            left  <= count;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data.digit_char  <= digit_to_ascii(top_digit);
            out_data.digit_count <= count_ext[3:0];
            out_data.last        <= (left == CNT_W'(1));
            out_data.error       <= 1'b0;
            left                 <= left - CNT_W'(1);
            if (left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_data.digit_char  <= 7'd0;
            out_data.digit_count <= 4'd0;
            out_data.last        <= 1'b1;
            out_data.error       <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An error response is always a lone, empty character.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |->
      (out_data.last && (out_data.digit_count == 4'd0) && (out_data.digit_char == 7'd0)))
    else $error("error response carries digit data");

  // A good response is always a legal digit character.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.error) |->
      (((out_data.digit_char >= ASCII_ZERO) && (out_data.digit_char <= 7'd57)) ||
       ((out_data.digit_char >= ASCII_A) && (out_data.digit_char <= 7'd70))))
    else $error("digit character out of range");

  // Emission never runs with nothing left to send.
  a_emit_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (left != '0))
    else $error("emission with empty digit count");

  // Trimming never removes the last digit.
  a_trim_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM) |-> (count != '0))
    else $error("digit count reached zero while trimming");

endmodule
